@@ rtl/core/uart_8e1_run_length_symbol_encoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 8E1 run-length symbol encoder
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef UART_8E1_RUN_LENGTH_SYMBOL_ENCODER_ASSERT_SVH
`define UART_8E1_RUN_LENGTH_SYMBOL_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define U8E_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define U8E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define U8E_ASSERT_SAME(lbl, ante, cons, msg)
`define U8E_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/u8e_rle_pkg.sv @@
// ----------------------------------------------------------------------------
// u8e_rle_pkg
// Types, constants and helper functions shared by the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none
package u8e_rle_pkg;

  localparam int unsigned FRAME_BITS  = 11;
  localparam int unsigned PTR_W       = 4;
  localparam int unsigned DUR_W       = 15;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned RUN_LIMIT   = 32767;
  localparam logic [DUR_W-1:0] BIT_TIME_RST = 15'd833;

  typedef logic [FRAME_BITS-1:0] frame_t;
  typedef logic [PTR_W-1:0]      ptr_t;

  typedef struct packed {
    logic [DUR_W-1:0] first_duration;
    logic             first_level;
    logic [DUR_W-1:0] second_duration;
    logic             second_level;
    logic             last;
    ptr_t             next_ptr;
  } sym_t;

  // Largest number of bits that fit in one run without passing the limit.
  function automatic ptr_t max_bits(input logic [DUR_W-1:0] bt);
    ptr_t k;
    k = '0;
    for (int j = 1; j <= FRAME_BITS; j++) begin
      if ((19'(j) * {4'b0, bt}) <= 19'(RUN_LIMIT)) begin
        k = PTR_W'(j);
      end
    end
    return k;
  endfunction

  // Inverted-line frame: start, data LSB first, even parity, stop.
  function automatic frame_t build_frame(input logic [BYTE_W-1:0] b);
    frame_t f;
    f[0]   = 1'b1;
    f[8:1] = ~b;
    f[9]   = ~(^b);
    f[10]  = 1'b0;
    return f;
  endfunction

  // Length of the run that starts at ptr, zero if ptr is past the frame.
  function automatic ptr_t run_len(input frame_t f, input ptr_t ptr, input ptr_t k);
    frame_t sh;
    ptr_t   len;
    ptr_t   rem;
    logic   stop;
    sh   = f >> ptr;
    rem  = PTR_W'(FRAME_BITS) - ptr;
    len  = (ptr < PTR_W'(FRAME_BITS)) ? PTR_W'(1) : '0;
    stop = (ptr >= PTR_W'(FRAME_BITS));
    for (int j = 1; j < FRAME_BITS; j++) begin
      if (!stop && (PTR_W'(j) < rem) && (sh[j] == sh[0]) && (PTR_W'(j) < k)) begin
        len = PTR_W'(j + 1);
      end else begin
        stop = 1'b1;
      end
    end
    return len;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/u8e_rle_symgen.sv @@
// ----------------------------------------------------------------------------
// u8e_rle_symgen
// Forms one symbol (one or two runs) starting at a bit position of the frame.
// ----------------------------------------------------------------------------
`default_nettype none
module u8e_rle_symgen (
  input  wire u8e_rle_pkg::frame_t          frame,
  input  wire u8e_rle_pkg::ptr_t            ptr,
  input  wire [u8e_rle_pkg::DUR_W-1:0]      bit_time,
  input  wire u8e_rle_pkg::ptr_t            k,
  output u8e_rle_pkg::sym_t                 sym
);

  u8e_rle_pkg::ptr_t   len1;
  u8e_rle_pkg::ptr_t   len2;
  u8e_rle_pkg::ptr_t   ptr2;
  u8e_rle_pkg::ptr_t   ptr3;
  u8e_rle_pkg::frame_t sh1;
  u8e_rle_pkg::frame_t sh2;
  logic [18:0]         dur1;
  logic [18:0]         dur2;
  logic                has2;

  always_comb begin
    len1 = u8e_rle_pkg::run_len(frame, ptr, k);
    ptr2 = ptr + len1;
    len2 = u8e_rle_pkg::run_len(frame, ptr2, k);
    ptr3 = ptr2 + len2;
    has2 = (len2 != '0);
    sh1  = frame >> ptr;
    sh2  = frame >> ptr2;
    dur1 = {15'b0, len1} * {4'b0, bit_time};
    dur2 = {15'b0, len2} * {4'b0, bit_time};
    sym.first_duration  = dur1[u8e_rle_pkg::DUR_W-1:0];
    sym.first_level     = sh1[0];
    sym.second_duration = has2 ? dur2[u8e_rle_pkg::DUR_W-1:0] : '0;
    sym.second_level    = has2 ? sh2[0] : 1'b0;
    sym.last            = (ptr3 >= u8e_rle_pkg::PTR_W'(u8e_rle_pkg::FRAME_BITS));
    sym.next_ptr        = ptr3;
  end

endmodule
`default_nettype wire

@@ rtl/core/uart_8e1_run_length_symbol_encoder.sv @@
// ----------------------------------------------------------------------------
// uart_8e1_run_length_symbol_encoder
// Expands each byte into an inverted 8E1 frame and emits its runs in pairs.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in_     | input     | in_tvalid/tready    | tdata: data_byte
//  out_    | output    | out_tvalid/tready   | tdata: durations, levels; tlast
//  cfg_    | input     | cfg_valid/ready     | cfg_data: bit_time
//
// One symbol leaves per cycle while the output is not stalled; a byte's frame
// holds one to six symbols, the number set by the symbol serializer.
// The next byte is accepted in the cycle its predecessor's last symbol loads.
// Reset is synchronous; bit_time returns to 833 ticks.
// A stall on the output holds the output register and the serializer.
`default_nettype none
module uart_8e1_run_length_symbol_encoder (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [7:0]  in_tdata,   // [7:0] data_byte
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // [14:0] first_duration, [15] first_level,
                                 // [30:16] second_duration, [31] second_level
  output logic       out_tlast,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [14:0] cfg_data
);

  logic                    busy_r, busy_nxt;
  u8e_rle_pkg::frame_t     frame_r, frame_nxt;
  u8e_rle_pkg::ptr_t       ptr_r, ptr_nxt;
  logic [14:0]             bit_time_r;
  u8e_rle_pkg::ptr_t       k_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_data_r;
  logic                    out_last_r;
  u8e_rle_pkg::sym_t       sym;
  logic                    load;
  logic                    in_acc;

  u8e_rle_symgen u_symgen (
    .frame    (frame_r),
    .ptr      (ptr_r),
    .bit_time (bit_time_r),
    .k        (k_r),
    .sym      (sym)
  );

  always_comb begin
    load          = busy_r && (!out_valid_r || out_tready);
    in_tready     = !busy_r || (load && sym.last);
    in_acc        = in_tvalid && in_tready;
    busy_nxt      = busy_r;
    ptr_nxt       = ptr_r;
    frame_nxt     = frame_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      ptr_nxt       = sym.next_ptr;
      if (sym.last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      busy_nxt  = 1'b1;
      ptr_nxt   = '0;
      frame_nxt = u8e_rle_pkg::build_frame(in_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      bit_time_r  <= u8e_rle_pkg::BIT_TIME_RST;
      k_r         <= u8e_rle_pkg::max_bits(u8e_rle_pkg::BIT_TIME_RST);
    end else begin
      busy_r      <= busy_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        bit_time_r <= cfg_data;
        k_r        <= u8e_rle_pkg::max_bits(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (load) begin
      out_data_r <= {sym.second_level, sym.second_duration,
                     sym.first_level, sym.first_duration};
      out_last_r <= sym.last;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`include "uart_8e1_run_length_symbol_encoder_assert.svh"

  `U8E_ASSERT_NEXT(a_accept_busy, in_acc, busy_r, "Accepted word did not start a frame.")
  `U8E_ASSERT_SAME(a_ptr_range, busy_r, ptr_r < 4'd11, "Serializer position passed the frame.")
  `U8E_ASSERT_SAME(a_ready_busy, in_tready && busy_r, load && sym.last, "Input ready mid-frame.")

endmodule
`default_nettype wire
